### rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and the field width constant for the signed fraction reducer.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // width of every transaction field word
  localparam int FIELD_W = 64;

  // input transaction payload
  typedef struct packed {
    logic signed [FIELD_W-1:0] numerator_in;
    logic signed [FIELD_W-1:0] denominator_in;
  } sfr_in_t;

  // result transaction payload
  typedef struct packed {
    logic signed [FIELD_W-1:0] numerator_out;
    logic signed [FIELD_W-1:0] denominator_out;
    logic                      success;
  } sfr_out_t;

endpackage

### rtl/core/sfr_div.sv
// ----------------------------------------------------------------------------
// sfr_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfr_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     q_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dvsr_r;

  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             ge;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_r, q_r[W-1]};
  assign diff   = rem_sh - {1'b0, dvsr_r};
  assign ge     = !diff[W];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out the top, quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[W-2:0], ge};
      rem_r <= ge ? diff[W-1:0] : rem_sh[W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/core/signed_fraction_reducer.sv
// ----------------------------------------------------------------------------
// signed_fraction_reducer
// Reduces a signed fraction to lowest terms by binary GCD and two divisions.
// ----------------------------------------------------------------------------
// A zero numerator or zero denominator is answered straight from idle; any other
//   fraction runs binary GCD, then two passes through the one bit-serial divider.
// Throughput: one transaction at a time; busy is high from acceptance until the
//   result strobe, and stays low for a zero numerator or zero denominator.
// Reset: synchronous active-low rst_n clears the state machine and strobe.
// The receiver cannot stall: out_valid is high for one cycle per result, and out_data holds until the next result.
module signed_fraction_reducer #(
  parameter int DATA_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sfr_pkg::sfr_in_t in_data,
  output logic             busy,
  output logic             out_valid,
  output sfr_pkg::sfr_out_t out_data
);

  localparam int W    = DATA_WIDTH;
  localparam int FW   = sfr_pkg::FIELD_W;
  localparam int K_W  = $clog2(W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_GCD  = 4'b0010,
    ST_DIVN = 4'b0100,
    ST_DIVD = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [W-1:0]      a_r, a_nxt;
  logic [W-1:0]      b_r, b_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [W-1:0]      nm_r, dm_r, g_r;
  logic [W-1:0]      nq_r;
  logic              neg_r;
  logic              out_valid_r, out_valid_nxt;
  sfr_pkg::sfr_out_t out_r, out_nxt;

  logic [W-1:0]      n_w, d_w, nm_w, dm_w;
  logic              accept;
  logic              gcd_end;
  logic [W-1:0]      g_val;
  logic [W-1:0]      a_m_b, b_m_a;
  logic              a_ge_b;
  logic [W-1:0]      nq_signed;

  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_dividend, div_divisor, div_quot;

  // sign-extend a word to the field width
  function automatic logic [FW-1:0] widen(input logic [W-1:0] x);
    logic signed [W-1:0] xs;
    xs = x;
    return FW'(xs);
  endfunction

  // input words and magnitudes
  assign n_w    = in_data.numerator_in[W-1:0];
  assign d_w    = in_data.denominator_in[W-1:0];
  assign nm_w   = n_w[W-1] ? (W'(0) - n_w) : n_w;
  assign dm_w   = d_w[W-1] ? (W'(0) - d_w) : d_w;
  assign accept = start && (state_r == ST_IDLE);

  // binary gcd step
  assign gcd_end = (a_r == '0) || (b_r == '0);
  assign g_val   = (a_r | b_r) << k_r;
  assign a_m_b   = a_r - b_r;
  assign b_m_a   = b_r - a_r;
  assign a_ge_b  = (a_r >= b_r);

  assign nq_signed = neg_r ? (W'(0) - nq_r) : nq_r;

  // shared divider
  sfr_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_start     = 1'b0;
    div_dividend  = nm_r;
    div_divisor   = g_val;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (dm_w == '0) begin
            out_valid_nxt           = 1'b1;
            out_nxt.numerator_out   = widen(n_w);
            out_nxt.denominator_out = widen(d_w);
            out_nxt.success         = 1'b0;
          end else if (nm_w == '0) begin
            out_valid_nxt           = 1'b1;
            out_nxt.numerator_out   = '0;
            out_nxt.denominator_out = FW'(1);
            out_nxt.success         = 1'b1;
          end else begin
            a_nxt     = nm_w;
            b_nxt     = dm_w;
            k_nxt     = '0;
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (gcd_end) begin
          div_start = 1'b1;
          state_nxt = ST_DIVN;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_ge_b) begin
          a_nxt = a_m_b >> 1;
        end else begin
          b_nxt = b_m_a >> 1;
        end
      end
      ST_DIVN: begin
        div_dividend = dm_r;
        div_divisor  = g_r;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_done) begin
          out_valid_nxt           = 1'b1;
          out_nxt.numerator_out   = widen(nq_signed);
          out_nxt.denominator_out = widen(div_quot);
          out_nxt.success         = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
    if (accept) begin
      nm_r  <= nm_w;
      dm_r  <= dm_w;
      neg_r <= n_w[W-1] ^ d_w[W-1];
    end
    if ((state_r == ST_GCD) && gcd_end) begin
      g_r <= g_val;
    end
    if ((state_r == ST_DIVN) && div_done) begin
      nq_r <= div_quot;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### dv/tb_signed_fraction_reducer.sv
// ----------------------------------------------------------------------------
// tb_signed_fraction_reducer
// Self-checking bench for the signed fraction reducer: a directed table of
// corner fractions, then bursts of random fractions, each result compared
// field by field against a hand-typed answer or a gcd-based prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signed_fraction_reducer;

  localparam int DW           = 64;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 500;
  localparam int DRAIN_CYCLES = 4 * DW + 40;
  localparam int STALL_LIMIT  = 8000;

  localparam logic [63:0] WMASK   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DW);
  localparam logic [63:0] SBIT    = 64'd1 << (DW - 1);
  localparam logic [63:0] MIN_W   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_W   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

  // one directed row: the fraction, and optionally a hand-typed answer
  typedef struct {
    sfr_pkg::sfr_in_t  stim;
    bit                typed;
    sfr_pkg::sfr_out_t golden;
  } stim_row_t;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  sfr_pkg::sfr_in_t  in_data = '0;
  logic              busy;
  logic              out_valid;
  sfr_pkg::sfr_out_t out_data;

  // hand-typed answer that travels with the transaction on the input side
  logic              typed_valid  = 1'b0;
  sfr_pkg::sfr_out_t typed_result = '0;

  sfr_pkg::sfr_out_t reduced_q[$];
  int                err_cnt     = 0;
  int                stall_cnt   = 0;
  stim_row_t         directed_tbl [NUM_DIRECTED];

  signed_fraction_reducer #(.DATA_WIDTH(DW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // sign-extend a DW-bit word to 64 bits
  function automatic logic [63:0] widen(logic [63:0] w);
    w = w & WMASK;
    if ((w & SBIT) != 0) w = w | ~WMASK;
    return w;
  endfunction

  // magnitude of a DW-bit word, the most negative one giving 2^(DW-1)
  function automatic logic [63:0] abs_word(logic [63:0] w);
    if ((w & SBIT) != 0) return (64'd0 - w) & WMASK;
    return w;
  endfunction

  // fraction in lowest terms, sign on the numerator, wrapping like C
  function automatic sfr_pkg::sfr_out_t reduce_fraction(sfr_pkg::sfr_in_t t);
    logic [63:0]       n;
    logic [63:0]       d;
    logic [63:0]       nm;
    logic [63:0]       dm;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [63:0]       r;
    logic              neg;
    sfr_pkg::sfr_out_t res;
    n   = t.numerator_in & WMASK;
    d   = t.denominator_in & WMASK;
    neg = ((n & SBIT) != 0) != ((d & SBIT) != 0);
    nm  = abs_word(n);
    dm  = abs_word(d);
    // zero denominator echoes the operands
    if (dm == 0) begin
      res.numerator_out   = widen(n);
      res.denominator_out = widen(d);
      res.success         = 1'b0;
      return res;
    end
    // zero numerator is always 0/1
    if (nm == 0) begin
      res.numerator_out   = 64'd0;
      res.denominator_out = 64'd1;
      res.success         = 1'b1;
      return res;
    end
    // euclid on the magnitudes
    a = nm;
    b = dm;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    nm = nm / a;
    dm = dm / a;
    if (neg) nm = 64'd0 - nm;
    res.numerator_out   = widen(nm);
    res.denominator_out = widen(dm);
    res.success         = 1'b1;
    return res;
  endfunction

  function automatic stim_row_t mk_row(logic [63:0] n, logic [63:0] d, bit typed = 1'b0,
                                       logic [63:0] en = '0, logic [63:0] ed = '0,
                                       bit es = 1'b0);
    stim_row_t row;
    row.stim.numerator_in      = n;
    row.stim.denominator_in    = d;
    row.typed                  = typed;
    row.golden.numerator_out   = en;
    row.golden.denominator_out = ed;
    row.golden.success         = es;
    return row;
  endfunction

  // random operand word, mixing corners, small values and full-width noise
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom} >> $urandom_range(1, 63);
      2: return 64'($signed($urandom_range(0, 200)) - 100);
      3: begin
        case ($urandom_range(0, 5))
          0: return 64'd0;
          1: return MIN_W;
          2: return MAX_W;
          3: return ALL_ONE;
          4: return 64'd1;
          default: return MIN_W + 64'd1;
        endcase
      end
      4: return 64'd1 << $urandom_range(0, 63);
      default: return 64'd0 - ({$urandom, $urandom} >> $urandom_range(1, 63));
    endcase
  endfunction

  // random fraction; about half share a random common factor
  function automatic sfr_pkg::sfr_in_t rand_fraction();
    sfr_pkg::sfr_in_t t;
    logic [63:0]      g;
    if ($urandom_range(0, 1) == 0) begin
      t.numerator_in   = rand_word();
      t.denominator_in = rand_word();
    end else begin
      g                = 64'($urandom) >> $urandom_range(0, 31);
      if (g == 0) g = 64'd1;
      t.numerator_in   = g * (64'($urandom) >> $urandom_range(0, 31));
      t.denominator_in = g * (64'($urandom) >> $urandom_range(0, 31));
      if ($urandom_range(0, 1) == 1) t.numerator_in = -t.numerator_in;
      if ($urandom_range(0, 1) == 1) t.denominator_in = -t.denominator_in;
    end
    return t;
  endfunction

  // hold one transaction on the input until it is taken
  task automatic send_fraction(sfr_pkg::sfr_in_t t, bit typed, sfr_pkg::sfr_out_t golden);
    in_data      <= t;
    typed_valid  <= typed;
    typed_result <= golden;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // one edge first so the last accepted transaction is already queued
  task automatic wait_all_results();
    @(posedge clk);
    while (reduced_q.size() != 0) @(posedge clk);
  endtask

  // result checker, prediction on acceptance, and stall watchdog
  always @(posedge clk) begin
    sfr_pkg::sfr_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (reduced_q.size() == 0) begin
          $display("%0t: unexpected result n=%h d=%h s=%b", $time,
                   out_data.numerator_out, out_data.denominator_out, out_data.success);
          err_cnt++;
        end else begin
          want = reduced_q.pop_front();
          if (out_data.numerator_out !== want.numerator_out) begin
            $display("%0t: numerator_out expected %h actual %h", $time,
                     want.numerator_out, out_data.numerator_out);
            err_cnt++;
          end
          if (out_data.denominator_out !== want.denominator_out) begin
            $display("%0t: denominator_out expected %h actual %h", $time,
                     want.denominator_out, out_data.denominator_out);
            err_cnt++;
          end
          if (out_data.success !== want.success) begin
            $display("%0t: success expected %b actual %b", $time,
                     want.success, out_data.success);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        reduced_q.push_back(typed_valid ? typed_result : reduce_fraction(in_data));
      end
    end
    if (out_valid || (start && !busy)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb_signed_fraction_reducer failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // stimulus
  initial begin
    int burst_left;
    int gap;
    directed_tbl = '{
      mk_row(64'd6, 64'd4),
      mk_row(64'd0, 64'd5, 1'b1, 64'd0, 64'd1, 1'b1),
      mk_row(64'd0, -64'sd5, 1'b1, 64'd0, 64'd1, 1'b1),
      mk_row(64'd0, MIN_W, 1'b1, 64'd0, 64'd1, 1'b1),
      mk_row(64'd5, 64'd0, 1'b1, 64'd5, 64'd0, 1'b0),
      mk_row(MIN_W, 64'd0, 1'b1, MIN_W, 64'd0, 1'b0),
      mk_row(ALL_ONE, 64'd0, 1'b1, ALL_ONE, 64'd0, 1'b0),
      mk_row(64'd0, 64'd0, 1'b1, 64'd0, 64'd0, 1'b0),
      mk_row(64'd1, MIN_W, 1'b1, ALL_ONE, MIN_W, 1'b1),
      mk_row(MIN_W, MIN_W, 1'b1, 64'd1, 64'd1, 1'b1),
      mk_row(MIN_W, 64'd1, 1'b1, MIN_W, 64'd1, 1'b1),
      mk_row(MIN_W, ALL_ONE, 1'b1, MIN_W, 64'd1, 1'b1),
      mk_row(MAX_W, MAX_W, 1'b1, 64'd1, 64'd1, 1'b1),
      mk_row(MAX_W, ALL_ONE, 1'b1, MIN_W + 64'd1, 64'd1, 1'b1),
      mk_row(ALL_ONE, ALL_ONE, 1'b1, 64'd1, 64'd1, 1'b1),
      mk_row(-64'sd6, 64'd4),
      mk_row(64'd6, -64'sd4),
      mk_row(-64'sd6, -64'sd4),
      mk_row(MAX_W, MIN_W),
      mk_row(64'd12345678900, 64'd98765432100),
      mk_row(ALL_ONE, 64'h5555_5555_5555_5555),
      mk_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_0000_0000)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_fraction(directed_tbl[i].stim, directed_tbl[i].typed, directed_tbl[i].golden);
    end
    start <= 1'b0;
    wait_all_results();

    // random bursts; one full drain halfway through
    burst_left = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        start <= 1'b0;
        wait_all_results();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 400) :
              ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_fraction(rand_fraction(), 1'b0, '0);
    end
    start <= 1'b0;

    // let everything drain, then give stray results a chance to show
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_signed_fraction_reducer passed");
    end else begin
      $display("tb_signed_fraction_reducer failed");
    end
    $finish;
  end

endmodule

### signed_fraction_reducer.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_div.sv
rtl/core/signed_fraction_reducer.sv
dv/tb_signed_fraction_reducer.sv
